// ===== design/hrd_pkg.sv =====
// shared types, constants and the header name table for the http response deframer
`default_nettype none

package hrd_pkg;

  localparam int LEN_BITS_DEFAULT = 32;
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [3:0] NAME_LEN = 4'd14;

  localparam logic [1:0] KIND_BODY     = 2'd0;
  localparam logic [1:0] KIND_HEADERS  = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_message;
  } hrd_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] body_byte;
    logic       is_chunked;
    logic       last_of_run;
  } hrd_out_t;

  // results caused by one byte, at most two
  typedef struct packed {
    logic [1:0] count;
    hrd_out_t   first;
    hrd_out_t   second;
  } hrd_emit_t;

  // "Content-Length", one character per position
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/hrd_parser.sv =====
// per-byte header and framing state machine, yields up to two results per byte
`default_nettype none

module hrd_parser
  import hrd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      take,
  input  wire hrd_in_t   item,
  output hrd_emit_t      emit
);

  typedef enum logic [3:0] {
    PH_HDR        = 4'd0,
    PH_BODY_LEN   = 4'd1,
    PH_CHUNK_SIZE = 4'd2,
    PH_CHUNK_DATA = 4'd3,
    PH_CHUNK_END  = 4'd4,
    PH_DONE       = 4'd5,
    PH_ERROR      = 4'd6
  } phase_t;

  phase_t              phase, phase_next;
  logic                prev_cr, prev_cr_next;
  logic                has_colon, has_colon_next;
  logic                line_empty, line_empty_next;
  logic [3:0]          name_pos, name_pos_next;
  logic                name_match, name_match_next;
  logic [LEN_BITS-1:0] acc, acc_next;
  logic                len_present, len_present_next;
  logic [LEN_BITS-1:0] remaining, remaining_next;
  logic                hex_done, hex_done_next;

  // current state as seen by this byte (start_message restarts first)
  phase_t              cur_phase;
  logic                cur_prev_cr;
  logic                cur_has_colon;
  logic                cur_line_empty;
  logic [3:0]          cur_name_pos;
  logic                cur_name_match;
  logic [LEN_BITS-1:0] cur_acc;
  logic                cur_len_present;
  logic [LEN_BITS-1:0] cur_remaining;
  logic                cur_hex_done;

  logic [7:0]          b;
  logic                eol;
  logic [LEN_BITS+3:0] dec_sum;
  logic                dec_digit;
  logic [3:0]          hex_val;
  logic                hex_digit;
  hrd_emit_t           res;

  function automatic hrd_out_t mk(input logic [1:0] k, input logic [7:0] d, input logic ch);
    hrd_out_t r;
    r.kind        = k;
    r.body_byte   = d;
    r.is_chunked  = ch;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    b = item.rx_byte;
    if (item.start_message) begin
      cur_phase       = PH_HDR;
      cur_prev_cr     = 1'b0;
      cur_has_colon   = 1'b0;
      cur_line_empty  = 1'b1;
      cur_name_pos    = '0;
      cur_name_match  = 1'b1;
      cur_acc         = '0;
      cur_len_present = 1'b0;
      cur_remaining   = '0;
      cur_hex_done    = 1'b0;
    end else begin
      cur_phase       = phase;
      cur_prev_cr     = prev_cr;
      cur_has_colon   = has_colon;
      cur_line_empty  = line_empty;
      cur_name_pos    = name_pos;
      cur_name_match  = name_match;
      cur_acc         = acc;
      cur_len_present = len_present;
      cur_remaining   = remaining;
      cur_hex_done    = hex_done;
    end
    eol = (b == CH_LF) && cur_prev_cr;

    // acc*10 + digit; overflow when anything lands above LEN_BITS
    dec_digit = (b >= 8'h30) && (b <= 8'h39);
    dec_sum = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1) + {{LEN_BITS{1'b0}}, 4'(b - 8'h30)};

    hex_digit = 1'b1;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      hex_val = 4'(b - 8'h30);
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      hex_val = 4'(b - 8'h57);
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      hex_val = 4'd0;
      hex_digit = 1'b0;
    end

    phase_next       = cur_phase;
    prev_cr_next     = cur_prev_cr;
    has_colon_next   = cur_has_colon;
    line_empty_next  = cur_line_empty;
    name_pos_next    = cur_name_pos;
    name_match_next  = cur_name_match;
    acc_next         = cur_acc;
    len_present_next = cur_len_present;
    remaining_next   = cur_remaining;
    hex_done_next    = cur_hex_done;
    res              = '0;

    case (cur_phase)
      PH_HDR: begin
        if (eol) begin
          if (!cur_line_empty) begin
            has_colon_next  = 1'b0;
            line_empty_next = 1'b1;
            name_pos_next   = '0;
            name_match_next = 1'b1;
          end else if (cur_len_present) begin
            res.first = mk(KIND_HEADERS, 8'd0, 1'b0);
            res.count = 2'd1;
            if (cur_acc == '0) begin
              res.second = mk(KIND_COMPLETE, 8'd0, 1'b0);
              res.count  = 2'd2;
              phase_next = PH_DONE;
            end else begin
              remaining_next = cur_acc;
              phase_next     = PH_BODY_LEN;
            end
          end else begin
            res.first     = mk(KIND_HEADERS, 8'd0, 1'b1);
            res.count     = 2'd1;
            acc_next      = '0;
            hex_done_next = 1'b0;
            phase_next    = PH_CHUNK_SIZE;
          end
          prev_cr_next = 1'b0;
        end else begin
          // a lone cr spoils the line for name matching
          if (cur_prev_cr) begin
            name_match_next = 1'b0;
            line_empty_next = 1'b0;
          end
          if (b != CH_CR) begin
            line_empty_next = 1'b0;
          end
          prev_cr_next = (b == CH_CR);
          if (!cur_has_colon) begin
            if (b == CH_COLON) begin
              has_colon_next = 1'b1;
              if (name_match_next && (cur_name_pos == NAME_LEN)) begin
                len_present_next = 1'b1;
                acc_next         = '0;
              end
            end else if ((cur_name_pos < NAME_LEN) && (b == name_char(cur_name_pos))) begin
              name_pos_next = cur_name_pos + 4'd1;
            end else begin
              name_match_next = 1'b0;
            end
          end else if (name_match_next && (cur_name_pos == NAME_LEN)) begin
            if (dec_digit) begin
              if (dec_sum[LEN_BITS+3:LEN_BITS] != 4'd0) begin
                res.first  = mk(KIND_OVERFLOW, 8'd0, 1'b0);
                res.count  = 2'd1;
                phase_next = PH_ERROR;
              end else begin
                acc_next = dec_sum[LEN_BITS-1:0];
              end
            end else if (b != CH_SPACE) begin
              name_match_next = 1'b0;
            end
          end
        end
      end

      PH_CHUNK_SIZE: begin
        if (eol) begin
          if (cur_acc == '0) begin
            res.first  = mk(KIND_COMPLETE, 8'd0, 1'b1);
            res.count  = 2'd1;
            phase_next = PH_DONE;
          end else begin
            remaining_next = cur_acc;
            phase_next     = PH_CHUNK_DATA;
          end
          prev_cr_next = 1'b0;
        end else begin
          prev_cr_next = (b == CH_CR);
          if (!cur_hex_done) begin
            if (!hex_digit) begin
              hex_done_next = 1'b1;
            end else if (cur_acc[LEN_BITS-1:LEN_BITS-4] != 4'd0) begin
              res.first  = mk(KIND_OVERFLOW, 8'd0, 1'b1);
              res.count  = 2'd1;
              phase_next = PH_ERROR;
            end else begin
              acc_next = {cur_acc[LEN_BITS-5:0], hex_val};
            end
          end
        end
      end

      PH_CHUNK_DATA: begin
        res.first      = mk(KIND_BODY, b, 1'b1);
        res.count      = 2'd1;
        remaining_next = cur_remaining - LEN_BITS'(1);
        if (cur_remaining == {{(LEN_BITS - 1){1'b0}}, 1'b1}) begin
          phase_next = PH_CHUNK_END;
        end
      end

      PH_CHUNK_END: begin
        // trailer bytes up to the lf are dropped
        if (b == CH_LF) begin
          acc_next      = '0;
          hex_done_next = 1'b0;
          prev_cr_next  = 1'b0;
          phase_next    = PH_CHUNK_SIZE;
        end
      end

      PH_BODY_LEN: begin
        res.first      = mk(KIND_BODY, b, 1'b0);
        res.count      = 2'd1;
        remaining_next = cur_remaining - LEN_BITS'(1);
        if (cur_remaining == {{(LEN_BITS - 1){1'b0}}, 1'b1}) begin
          res.second = mk(KIND_COMPLETE, 8'd0, 1'b0);
          res.count  = 2'd2;
          phase_next = PH_DONE;
        end
      end

      default: begin
      end
    endcase

    if (res.count == 2'd1) begin
      res.first.last_of_run = 1'b1;
    end
    if (res.count == 2'd2) begin
      res.second.last_of_run = 1'b1;
    end
    emit = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR;
      prev_cr     <= 1'b0;
      has_colon   <= 1'b0;
      line_empty  <= 1'b1;
      name_pos    <= '0;
      name_match  <= 1'b1;
      acc         <= '0;
      len_present <= 1'b0;
      remaining   <= '0;
      hex_done    <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      prev_cr     <= prev_cr_next;
      has_colon   <= has_colon_next;
      line_empty  <= line_empty_next;
      name_pos    <= name_pos_next;
      name_match  <= name_match_next;
      acc         <= acc_next;
      len_present <= len_present_next;
      remaining   <= remaining_next;
      hex_done    <= hex_done_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/http_response_deframer.sv =====
// top level: byte parser feeding a four-entry result queue
// ordering: results of a taken byte are registered into the queue and offered on out_data behind any older results
// throughput: one byte per cycle; a byte with two results fills two queue entries on the output side,
//   and in_ready drops while fewer than two queue entries are free
// reset: synchronous rst clears the parser to header line start and empties the queue
`default_nettype none

module http_response_deframer
  import hrd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire hrd_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hrd_out_t      out_data
);

  localparam int PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS = PTR_BITS + 1;

  hrd_emit_t            emit;
  logic                 take;
  logic                 pop;
  hrd_out_t             queue [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [PTR_BITS-1:0]  wr_ptr_second;
  logic [CNT_BITS-1:0]  count, count_next;
  logic [CNT_BITS-1:0]  push_n;

  hrd_parser #(
    .LEN_BITS(LEN_BITS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_data),
    .emit (emit)
  );

  // room for the worst case of two results
  assign in_ready  = (count <= CNT_BITS'(FIFO_DEPTH - 2));
  assign take      = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_data  = queue[rd_ptr];
  assign pop       = out_valid && out_ready;

  assign wr_ptr_second = wr_ptr + PTR_BITS'(1);
  assign push_n        = take ? CNT_BITS'(emit.count) : '0;
  assign count_next    = count + push_n - CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (take && (emit.count != 2'd0)) begin
      queue[wr_ptr] <= emit.first;
    end
    if (take && (emit.count == 2'd2)) begin
      queue[wr_ptr_second] <= emit.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_results_shown: assert property (@(posedge clk) disable iff (rst)
    (take && (emit.count != 2'd0)) |=> out_valid)
    else $error("results of a taken byte not offered");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("queue not empty after reset");

  a_last_marks_run: assert property (@(posedge clk) disable iff (rst)
    (take && (emit.count == 2'd2)) |-> (!emit.first.last_of_run && emit.second.last_of_run))
    else $error("last_of_run misplaced in a two-result run");

endmodule

`default_nettype wire
